@@ design/jtn_pkg.sv @@
package jtn_pkg;

	localparam int TMS_WORD_BITS = 64;
	localparam int FILL_W        = $clog2(TMS_WORD_BITS + 1);
	localparam int NUM_TAP       = 16;
	localparam int PATH_BITS_W   = 32;
	localparam int MAX_DEPTH     = 31;

	localparam logic [4:0]  TAP_UNKNOWN = 5'd16;
	localparam logic [63:0] RESET_WORD  = 64'h1F;
	localparam logic [6:0]  RESET_BITS  = 7'd5;

	localparam logic [3:0] TAP_TLR  = 4'd0;
	localparam logic [3:0] TAP_RTI  = 4'd1;
	localparam logic [3:0] TAP_SDR  = 4'd2;
	localparam logic [3:0] TAP_CDR  = 4'd3;
	localparam logic [3:0] TAP_SHDR = 4'd4;
	localparam logic [3:0] TAP_E1DR = 4'd5;
	localparam logic [3:0] TAP_PDR  = 4'd6;
	localparam logic [3:0] TAP_E2DR = 4'd7;
	localparam logic [3:0] TAP_UDR  = 4'd8;
	localparam logic [3:0] TAP_SIR  = 4'd9;
	localparam logic [3:0] TAP_CIR  = 4'd10;
	localparam logic [3:0] TAP_SHIR = 4'd11;
	localparam logic [3:0] TAP_E1IR = 4'd12;
	localparam logic [3:0] TAP_PIR  = 4'd13;
	localparam logic [3:0] TAP_E2IR = 4'd14;
	localparam logic [3:0] TAP_UIR  = 4'd15;

	typedef logic [TMS_WORD_BITS-1:0] tms_buf_t;
	typedef logic [FILL_W-1:0]        fill_t;

	typedef enum logic [1:0] {HOLD_NONE, HOLD_ZERO, HOLD_ONE} hold_t;
	typedef enum logic [1:0] {ERR_OK, ERR_TARGET, ERR_WAIT} err_t;
	typedef enum logic [1:0] {EM_NONE, EM_RESET, EM_BUF, EM_STATUS} emit_t;
	typedef enum logic [2:0] {OP_NONE, OP_LATCH, OP_TAP_RST, OP_PATH, OP_WAIT} op_t;

	typedef struct packed {
		emit_t emit;
		op_t   op;
		err_t  err;
		logic  st_tgt;
	} ctrl_t;

	typedef struct packed {
		logic is_flush;
		logic bad_tgt;
		logic bad_wait;
		logic tap_known;
		logic fits;
		logic not_full;
		logic wait_zero;
		logic buf_empty;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic [4:0]             len;
		logic [PATH_BITS_W-1:0] bits;
	} path_t;

	typedef path_t [NUM_TAP*NUM_TAP-1:0] path_tab_t;

	function automatic logic [3:0] tap_next(logic [3:0] s, logic tms);
		logic [3:0] nxt;
		case (s)
			TAP_TLR:  nxt = tms ? TAP_TLR  : TAP_RTI;
			TAP_RTI:  nxt = tms ? TAP_SDR  : TAP_RTI;
			TAP_SDR:  nxt = tms ? TAP_SIR  : TAP_CDR;
			TAP_CDR:  nxt = tms ? TAP_E1DR : TAP_SHDR;
			TAP_SHDR: nxt = tms ? TAP_E1DR : TAP_SHDR;
			TAP_E1DR: nxt = tms ? TAP_UDR  : TAP_PDR;
			TAP_PDR:  nxt = tms ? TAP_E2DR : TAP_PDR;
			TAP_E2DR: nxt = tms ? TAP_UDR  : TAP_SHDR;
			TAP_UDR:  nxt = tms ? TAP_SDR  : TAP_RTI;
			TAP_SIR:  nxt = tms ? TAP_TLR  : TAP_CIR;
			TAP_CIR:  nxt = tms ? TAP_E1IR : TAP_SHIR;
			TAP_SHIR: nxt = tms ? TAP_E1IR : TAP_SHIR;
			TAP_E1IR: nxt = tms ? TAP_UIR  : TAP_PIR;
			TAP_PIR:  nxt = tms ? TAP_E2IR : TAP_PIR;
			TAP_E2IR: nxt = tms ? TAP_UIR  : TAP_SHIR;
			TAP_UIR:  nxt = tms ? TAP_SDR  : TAP_RTI;
			default:  nxt = TAP_TLR;
		endcase
		return nxt;
	endfunction

	function automatic hold_t hold_kind(logic [3:0] s);
		hold_t k;
		case (s)
			TAP_TLR:  k = HOLD_ONE;
			TAP_RTI:  k = HOLD_ZERO;
			TAP_SHDR: k = HOLD_ZERO;
			TAP_PDR:  k = HOLD_ZERO;
			TAP_SHIR: k = HOLD_ZERO;
			TAP_PIR:  k = HOLD_ZERO;
			default:  k = HOLD_NONE;
		endcase
		return k;
	endfunction

	function automatic tms_buf_t low_mask(fill_t k);
		tms_buf_t m;
		if (int'(k) >= TMS_WORD_BITS)
			m = '1;
		else
			m = (tms_buf_t'(1) << k) - tms_buf_t'(1);
		return m;
	endfunction

	// depth-first search, TMS=0 branch first, equal-length paths overwrite
	function automatic path_tab_t build_paths();
		path_tab_t              res;
		logic [7:0]             plen [NUM_TAP*NUM_TAP];
		logic [PATH_BITS_W-1:0] pb [NUM_TAP*NUM_TAP];
		logic [3:0]             st_cur [MAX_DEPTH+1];
		logic [PATH_BITS_W-1:0] st_bits [MAX_DEPTH+1];
		logic [1:0]             st_ph [MAX_DEPTH+1];
		int                     sp;
		int                     lvl;
		int                     idx;
		for (int i = 0; i < NUM_TAP*NUM_TAP; i++) begin
			plen[i] = 8'hFF;
			pb[i]   = '0;
		end
		for (int o = 0; o < NUM_TAP; o++) begin
			sp         = 1;
			st_cur[0]  = 4'(o);
			st_bits[0] = '0;
			st_ph[0]   = 2'd0;
			while (sp > 0) begin
				lvl = sp - 1;
				idx = o * NUM_TAP + int'(st_cur[lvl]);
				if (st_ph[lvl] == 2'd0) begin
					if (lvl > int'(plen[idx]) || lvl >= MAX_DEPTH) begin
						sp = sp - 1;
					end else begin
						pb[idx]     = st_bits[lvl];
						plen[idx]   = 8'(lvl);
						st_ph[lvl]  = 2'd1;
						st_cur[sp]  = tap_next(st_cur[lvl], 1'b0);
						st_bits[sp] = st_bits[lvl];
						st_ph[sp]   = 2'd0;
						sp          = sp + 1;
					end
				end else if (st_ph[lvl] == 2'd1) begin
					st_ph[lvl]  = 2'd2;
					st_cur[sp]  = tap_next(st_cur[lvl], 1'b1);
					st_bits[sp] = st_bits[lvl] | (PATH_BITS_W'(1) << lvl);
					st_ph[sp]   = 2'd0;
					sp          = sp + 1;
				end else begin
					sp = sp - 1;
				end
			end
		end
		for (int i = 0; i < NUM_TAP*NUM_TAP; i++) begin
			res[i].len  = plen[i][4:0];
			res[i].bits = pb[i];
		end
		return res;
	endfunction

	localparam path_tab_t PATH_TAB = build_paths();

endpackage

@@ design/jtn_useq.sv @@
module jtn_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  jtn_pkg::flags_t flags,
	output jtn_pkg::ctrl_t  ctrl,
	output logic            in_stall
);
	import jtn_pkg::*;

	typedef enum logic [3:0] {
		C_NEXT, C_ALWAYS, C_NO_REQ, C_FLUSH, C_BAD_TGT, C_BAD_WAIT,
		C_TAP_KNOWN, C_FITS, C_NOT_FULL, C_WAIT_ZERO, C_BUF_EMPTY
	} cond_t;

	typedef logic [4:0] pc_t;

	typedef struct packed {
		emit_t emit;
		op_t   op;
		err_t  err;
		logic  st_tgt;
		cond_t cond;
		pc_t   jmp;
	} uword_t;

	localparam pc_t PC_IDLE      = 5'd0;
	localparam pc_t PC_CHK_FLUSH = 5'd1;
	localparam pc_t PC_CHK_TGT   = 5'd2;
	localparam pc_t PC_CHK_WAIT  = 5'd3;
	localparam pc_t PC_CHK_TAP   = 5'd4;
	localparam pc_t PC_RESET     = 5'd5;
	localparam pc_t PC_PATH_CHK  = 5'd6;
	localparam pc_t PC_PATH_FLSH = 5'd7;
	localparam pc_t PC_PATH      = 5'd8;
	localparam pc_t PC_FULL_CHK  = 5'd9;
	localparam pc_t PC_FULL_EMIT = 5'd10;
	localparam pc_t PC_WAIT_CHK  = 5'd11;
	localparam pc_t PC_WAIT_FILL = 5'd12;
	localparam pc_t PC_DONE      = 5'd13;
	localparam pc_t PC_FLUSH     = 5'd14;
	localparam pc_t PC_FLUSH_BUF = 5'd15;
	localparam pc_t PC_ERR_TGT   = 5'd16;
	localparam pc_t PC_ERR_WAIT  = 5'd17;

	function automatic uword_t uw(emit_t e, op_t o, err_t er, logic st, cond_t c, pc_t j);
		uword_t w;
		w.emit   = e;
		w.op     = o;
		w.err    = er;
		w.st_tgt = st;
		w.cond   = c;
		w.jmp    = j;
		return w;
	endfunction

	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		case (pc)
			PC_IDLE:      w = uw(EM_NONE,   OP_LATCH,   ERR_OK,     1'b0, C_NO_REQ,    PC_IDLE);
			PC_CHK_FLUSH: w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_FLUSH,     PC_FLUSH);
			PC_CHK_TGT:   w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_BAD_TGT,   PC_ERR_TGT);
			PC_CHK_WAIT:  w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_BAD_WAIT,  PC_ERR_WAIT);
			PC_CHK_TAP:   w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_TAP_KNOWN, PC_PATH_CHK);
			PC_RESET:     w = uw(EM_RESET,  OP_TAP_RST, ERR_OK,     1'b1, C_NEXT,      PC_IDLE);
			PC_PATH_CHK:  w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_FITS,      PC_PATH);
			PC_PATH_FLSH: w = uw(EM_BUF,    OP_NONE,    ERR_OK,     1'b1, C_NEXT,      PC_IDLE);
			PC_PATH:      w = uw(EM_NONE,   OP_PATH,    ERR_OK,     1'b0, C_NEXT,      PC_IDLE);
			PC_FULL_CHK:  w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_NOT_FULL,  PC_WAIT_CHK);
			PC_FULL_EMIT: w = uw(EM_BUF,    OP_NONE,    ERR_OK,     1'b1, C_NEXT,      PC_IDLE);
			PC_WAIT_CHK:  w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_WAIT_ZERO, PC_DONE);
			PC_WAIT_FILL: w = uw(EM_NONE,   OP_WAIT,    ERR_OK,     1'b0, C_ALWAYS,    PC_FULL_CHK);
			PC_DONE:      w = uw(EM_STATUS, OP_NONE,    ERR_OK,     1'b0, C_ALWAYS,    PC_IDLE);
			PC_FLUSH:     w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_BUF_EMPTY, PC_DONE);
			PC_FLUSH_BUF: w = uw(EM_BUF,    OP_NONE,    ERR_OK,     1'b0, C_ALWAYS,    PC_DONE);
			PC_ERR_TGT:   w = uw(EM_STATUS, OP_NONE,    ERR_TARGET, 1'b0, C_ALWAYS,    PC_IDLE);
			PC_ERR_WAIT:  w = uw(EM_STATUS, OP_NONE,    ERR_WAIT,   1'b0, C_ALWAYS,    PC_IDLE);
			default:      w = uw(EM_NONE,   OP_NONE,    ERR_OK,     1'b0, C_ALWAYS,    PC_IDLE);
		endcase
		return w;
	endfunction

	pc_t    pc_q;
	pc_t    pc_d;
	uword_t cur;
	logic   hit;
	logic   go;

	always_comb begin
		cur = ucode(pc_q);
		case (cur.cond)
			C_NEXT:      hit = 1'b0;
			C_ALWAYS:    hit = 1'b1;
			C_NO_REQ:    hit = !in_valid;
			C_FLUSH:     hit = flags.is_flush;
			C_BAD_TGT:   hit = flags.bad_tgt;
			C_BAD_WAIT:  hit = flags.bad_wait;
			C_TAP_KNOWN: hit = flags.tap_known;
			C_FITS:      hit = flags.fits;
			C_NOT_FULL:  hit = flags.not_full;
			C_WAIT_ZERO: hit = flags.wait_zero;
			C_BUF_EMPTY: hit = flags.buf_empty;
			default:     hit = 1'b0;
		endcase
		// a step that produces a word waits for the output register
		go = !((cur.emit != EM_NONE) && flags.out_busy);
		if (!go)
			pc_d = pc_q;
		else if (hit)
			pc_d = cur.jmp;
		else
			pc_d = pc_q + pc_t'(1);
		ctrl.emit   = go ? cur.emit : EM_NONE;
		ctrl.op     = go ? cur.op : OP_NONE;
		ctrl.err    = cur.err;
		ctrl.st_tgt = cur.st_tgt;
	end

	assign in_stall = (pc_q != PC_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= PC_IDLE;
		else
			pc_q <= pc_d;
	end

endmodule

@@ design/jtn_dp.sv @@
module jtn_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_type,
	input  logic [4:0]      goal_state,
	input  logic [10:0]     wait_cycles,
	input  logic            out_stall,
	input  jtn_pkg::ctrl_t  ctrl,
	output jtn_pkg::flags_t flags,
	output logic            out_valid,
	output logic            word_valid,
	output logic [63:0]     tms_word,
	output logic [6:0]      word_bits,
	output logic [1:0]      error_code,
	output logic [4:0]      tap_state_now,
	output logic            last
);
	import jtn_pkg::*;

	logic        req_q;
	logic [4:0]  tgt_q;
	logic [10:0] wait_q;
	logic [4:0]  tap_q;
	tms_buf_t    buf_q;
	fill_t       fill_q;

	logic        out_valid_q;
	logic        out_wvalid_q;
	logic [63:0] out_word_q;
	logic [6:0]  out_bits_q;
	err_t        out_err_q;
	logic [4:0]  out_state_q;
	logic        out_last_q;

	path_t       ent;
	logic [4:0]  path_len;
	fill_t       space;
	fill_t       chunk;
	fill_t       fill_path;
	fill_t       fill_chunk;
	tms_buf_t    path_ins;
	tms_buf_t    wait_ins;

	always_comb begin
		ent        = PATH_TAB[{tap_q[3:0], tgt_q[3:0]}];
		path_len   = (int'(ent.len) > TMS_WORD_BITS) ? 5'd0 : ent.len;
		space      = fill_t'(TMS_WORD_BITS) - fill_q;
		chunk      = (11'(space) > wait_q) ? fill_t'(wait_q) : space;
		fill_path  = fill_q + fill_t'(path_len);
		fill_chunk = fill_q + chunk;
		path_ins   = (tms_buf_t'(ent.bits) & low_mask(fill_t'(path_len))) << fill_q;
		wait_ins   = (hold_kind(tgt_q[3:0]) == HOLD_ONE) ?
		             (low_mask(fill_chunk) & ~low_mask(fill_q)) : '0;

		flags.is_flush  = req_q;
		flags.bad_tgt   = tgt_q[4];
		flags.bad_wait  = (wait_q != 11'd0) && (hold_kind(tgt_q[3:0]) == HOLD_NONE);
		flags.tap_known = !tap_q[4];
		flags.fits      = int'(space) >= int'(path_len);
		flags.not_full  = (int'(fill_q) != TMS_WORD_BITS);
		flags.wait_zero = (wait_q == 11'd0);
		flags.buf_empty = (fill_q == '0);
		flags.out_busy  = out_valid_q && out_stall;
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LATCH: begin
				req_q  <= req_type;
				tgt_q  <= goal_state;
				wait_q <= wait_cycles;
			end
			OP_WAIT: begin
				wait_q <= wait_q - 11'(chunk);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= TAP_UNKNOWN;
			buf_q  <= '0;
			fill_q <= '0;
		end else begin
			case (ctrl.op)
				OP_TAP_RST: begin
					tap_q <= {1'b0, TAP_TLR};
				end
				OP_PATH: begin
					buf_q  <= buf_q | path_ins;
					fill_q <= fill_path;
					tap_q  <= tgt_q;
				end
				OP_WAIT: begin
					buf_q  <= buf_q | wait_ins;
					fill_q <= fill_chunk;
				end
				default: begin
				end
			endcase
			if (ctrl.emit == EM_BUF) begin
				buf_q  <= '0;
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.emit != EM_NONE)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (ctrl.emit)
			EM_RESET: begin
				out_wvalid_q <= 1'b1;
				out_word_q   <= RESET_WORD;
				out_bits_q   <= RESET_BITS;
				out_err_q    <= ERR_OK;
				out_state_q  <= tgt_q;
				out_last_q   <= 1'b0;
			end
			EM_BUF: begin
				out_wvalid_q <= 1'b1;
				out_word_q   <= 64'(buf_q);
				out_bits_q   <= 7'(fill_q);
				out_err_q    <= ERR_OK;
				out_state_q  <= ctrl.st_tgt ? tgt_q : tap_q;
				out_last_q   <= 1'b0;
			end
			EM_STATUS: begin
				out_wvalid_q <= 1'b0;
				out_word_q   <= '0;
				out_bits_q   <= '0;
				out_err_q    <= ctrl.err;
				out_state_q  <= tap_q;
				out_last_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign word_valid    = out_wvalid_q;
	assign tms_word      = out_word_q;
	assign word_bits     = out_bits_q;
	assign error_code    = out_err_q;
	assign tap_state_now = out_state_q;
	assign last          = out_last_q;

endmodule

@@ design/jtn_top.sv @@
// JTAG TMS navigator. Each request word (goto or flush) is taken while the
// sequencer sits at its idle step, and it produces one or more result words
// ending in a status word with last set. A reset word, an early flush, a full
// buffer and every chunk of wait bits (one chunk per 64-bit TMS word filled)
// each take their own microcode steps, and a flush with a partial word pending
// first emits that word. The rate is set by the microcode program, which runs
// one step per cycle while the output register is not stalled. After reset the
// tracked TAP state is unknown, so the first goto that passes the target and
// wait checks emits a 5-bit reset word. The input is taken again as soon as
// the status word is loaded into the output register.
module jtag_tap_tms_navigator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [4:0]  goal_state,
	input  logic [10:0] wait_cycles,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        word_valid,
	output logic [63:0] tms_word,
	output logic [6:0]  word_bits,
	output logic [1:0]  error_code,
	output logic [4:0]  tap_state_now,
	output logic        last
);
	import jtn_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	jtn_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.ctrl     (ctrl),
		.in_stall (in_stall)
	);

	jtn_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.goal_state    (goal_state),
		.wait_cycles   (wait_cycles),
		.out_stall     (out_stall),
		.ctrl          (ctrl),
		.flags         (flags),
		.out_valid     (out_valid),
		.word_valid    (word_valid),
		.tms_word      (tms_word),
		.word_bits     (word_bits),
		.error_code    (error_code),
		.tap_state_now (tap_state_now),
		.last          (last)
	);

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer stayed idle after taking a request");

	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !word_valid) |-> (tms_word == 64'd0 && word_bits == 7'd0 && last))
		else $error("status word carries TMS bits");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_OK) |-> (last && !word_valid))
		else $error("error reported on a TMS word");
`endif

endmodule

@@ bench/jtag_tap_tms_navigator_top_test.sv @@
`timescale 1ns / 1ps

module jtag_tap_tms_navigator_top_test;
	import jtn_pkg::*;

	localparam logic REQ_GOTO  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 60;

	// next TAP state per state, one nibble each, state 0 in the low nibble
	localparam logic [63:0] NEXT_ON0 = 64'h1BDD_BBA1_4664_4311;
	localparam logic [63:0] NEXT_ON1 = 64'h2FEF_CC02_8785_5920;
	// states that may hold: TLR, RTI, shift-DR, pause-DR, shift-IR, pause-IR
	localparam logic [15:0] HOLD_MASK = 16'h2853;

	typedef struct {
		logic        rq;
		logic [4:0]  tgt;
		logic [10:0] wt;
		logic        drain;
	} tms_req_t;

	typedef struct {
		logic        wv;
		logic [63:0] word;
		logic [6:0]  nbits;
		logic [1:0]  err;
		logic [4:0]  st;
		logic        lst;
	} tms_result_t;

	typedef struct {
		logic [3:0]  st;
		logic [31:0] bits;
		int          depth;
	} walk_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [4:0]  goal_state = '0;
	logic [10:0] wait_cycles = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        word_valid;
	logic [63:0] tms_word;
	logic [6:0]  word_bits;
	logic [1:0]  error_code;
	logic [4:0]  tap_state_now;
	logic        last;

	tms_req_t    pending_reqs[$];
	tms_result_t tms_expect_q[$];
	tms_req_t    next_req;
	tms_result_t want_r;

	int          route_len [16][16];
	logic [31:0] route_bits [16][16];

	logic [4:0]  model_tap;
	logic [63:0] model_buf;
	int          model_fill;

	int  expect_total = 0;
	int  got_total = 0;
	int  accepted_n = 0;
	int  flush_n = 0;
	int  reject_n = 0;
	int  mismatches = 0;
	int  cycle_n = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	bit  keep_item;

	jtag_tap_tms_navigator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.goal_state(goal_state),
		.wait_cycles(wait_cycles),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_valid(word_valid),
		.tms_word(tms_word),
		.word_bits(word_bits),
		.error_code(error_code),
		.tap_state_now(tap_state_now),
		.last(last)
	);

	// depth-first walk, TMS=0 branch first, ties keep the later path
	function automatic void build_routes();
		walk_t stack[$];
		walk_t w;
		walk_t nxt;
		for (int o = 0; o < 16; o++) begin
			for (int d = 0; d < 16; d++) begin
				route_len[o][d]  = 255;
				route_bits[o][d] = '0;
			end
		end
		for (int o = 0; o < 16; o++) begin
			w.st    = 4'(o);
			w.bits  = '0;
			w.depth = 0;
			stack.push_back(w);
			while (stack.size() > 0) begin
				w = stack.pop_back();
				if (w.depth <= route_len[o][w.st] && w.depth < 31) begin
					route_len[o][w.st]  = w.depth;
					route_bits[o][w.st] = w.bits;
					nxt.depth = w.depth + 1;
					nxt.st    = NEXT_ON1[int'(w.st)*4 +: 4];
					nxt.bits  = w.bits | (32'd1 << w.depth);
					stack.push_back(nxt);
					nxt.st    = NEXT_ON0[int'(w.st)*4 +: 4];
					nxt.bits  = w.bits;
					stack.push_back(nxt);
				end
			end
		end
	endfunction

	function automatic hold_t hold_of(logic [3:0] s);
		hold_t k;
		if (!HOLD_MASK[s])
			k = HOLD_NONE;
		else if (s == TAP_TLR)
			k = HOLD_ONE;
		else
			k = HOLD_ZERO;
		return k;
	endfunction

	function automatic void push_result(logic wv, logic [63:0] word, logic [6:0] nb, err_t err,
			logic [4:0] st, logic lst);
		tms_result_t r;
		r.wv    = wv;
		r.word  = word;
		r.nbits = nb;
		r.err   = err;
		r.st    = st;
		r.lst   = lst;
		tms_expect_q.push_back(r);
	endfunction

	function automatic void dump_partial(logic [4:0] st);
		if (model_fill > 0) begin
			push_result(1'b1, model_buf, 7'(model_fill), ERR_OK, st, 1'b0);
			model_buf  = '0;
			model_fill = 0;
		end
	endfunction

	function automatic void append_tms(logic [63:0] bits, int n, logic [4:0] st);
		logic [63:0] mask;
		if (n > 0) begin
			mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			model_buf  = model_buf | ((bits & mask) << model_fill);
			model_fill = model_fill + n;
			if (model_fill >= TMS_WORD_BITS)
				dump_partial(st);
		end
	endfunction

	// returns the number of result words the request produces
	function automatic int predict_tms(logic rq, logic [4:0] tgt, logic [10:0] wt);
		int          n0;
		int          plen;
		int          left;
		int          chunk;
		logic [63:0] pat;
		hold_t       hk;
		n0 = tms_expect_q.size();
		if (rq == REQ_FLUSH) begin
			flush_n++;
			dump_partial(model_tap);
			push_result(1'b0, '0, '0, ERR_OK, model_tap, 1'b1);
		end else if (tgt >= TAP_UNKNOWN) begin
			reject_n++;
			push_result(1'b0, '0, '0, ERR_TARGET, model_tap, 1'b1);
		end else begin
			hk = hold_of(tgt[3:0]);
			if (wt != 0 && hk == HOLD_NONE) begin
				reject_n++;
				push_result(1'b0, '0, '0, ERR_WAIT, model_tap, 1'b1);
			end else begin
				if (model_tap == TAP_UNKNOWN) begin
					push_result(1'b1, RESET_WORD, RESET_BITS, ERR_OK, tgt, 1'b0);
					model_tap = {1'b0, TAP_TLR};
				end
				plen = route_len[model_tap[3:0]][tgt[3:0]];
				if (TMS_WORD_BITS - model_fill < plen)
					dump_partial(tgt);
				append_tms({32'd0, route_bits[model_tap[3:0]][tgt[3:0]]}, plen, tgt);
				model_tap = tgt;
				pat  = (hk == HOLD_ONE) ? '1 : '0;
				left = wt;
				while (left > 0) begin
					chunk = TMS_WORD_BITS - model_fill;
					if (left < chunk)
						chunk = left;
					append_tms(pat, chunk, tgt);
					left = left - chunk;
				end
				push_result(1'b0, '0, '0, ERR_OK, tgt, 1'b1);
			end
		end
		return tms_expect_q.size() - n0;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	task automatic add_req(logic rq, logic [4:0] tgt, logic [10:0] wt, logic drain);
		tms_req_t q;
		q.rq    = rq;
		q.tgt   = tgt;
		q.wt    = wt;
		q.drain = drain;
		pending_reqs.push_back(q);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			req_type     <= 1'b0;
			goal_state   <= '0;
			wait_cycles  <= '0;
			expect_total <= 0;
		end else begin
			keep_item = in_valid;
			if (in_valid && !in_stall) begin
				expect_total <= expect_total + predict_tms(req_type, goal_state, wait_cycles);
				accepted_n++;
				keep_item = 1'b0;
			end
			if (!keep_item) begin
				if (pending_reqs.size() > 0
						&& !(pending_reqs[0].drain && (in_valid || expect_total != got_total))
						&& ((accepted_n >= 150 && accepted_n < 230) || $urandom_range(99) >= 19)) begin
					next_req = pending_reqs.pop_front();
					in_valid     <= 1'b1;
					req_type     <= next_req.rq;
					goal_state   <= next_req.tgt;
					wait_cycles  <= next_req.wt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			got_total <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_total <= got_total + 1;
				if (tms_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: expected no word, got tms_word %0h bits %0d", $time,
						tms_word, word_bits);
				end else begin
					want_r = tms_expect_q.pop_front();
					check_field("word_valid", want_r.wv, word_valid);
					check_field("tms_word", want_r.word, tms_word);
					check_field("word_bits", want_r.nbits, word_bits);
					check_field("error_code", want_r.err, error_code);
					check_field("tap_state_now", want_r.st, tap_state_now);
					check_field("last", want_r.lst, last);
				end
			end
			if (!hold_done && got_total >= 100) begin
				hold_left = 400;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !(got_total >= 300 && got_total < 600) && $urandom_range(99) < 19;
			end
		end
	end

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		int          roll;
		int          sz;
		logic [4:0]  tgt;
		logic [10:0] wt;
		logic        drain;
		build_routes();
		model_tap  = TAP_UNKNOWN;
		model_buf  = '0;
		model_fill = 0;

		// state unknown: flush, bad targets, bad wait
		add_req(REQ_FLUSH, 5'd0, 11'd0, 1'b0);
		add_req(REQ_GOTO, 5'd31, 11'd2047, 1'b0);
		add_req(REQ_GOTO, 5'd16, 11'd0, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_SDR}, 11'd1, 1'b0);
		// first goto emits the reset word
		add_req(REQ_GOTO, {1'b0, TAP_TLR}, 11'd0, 1'b0);
		// fill to 60 bits, then a 5-bit path forces an early flush
		add_req(REQ_GOTO, {1'b0, TAP_RTI}, 11'd55, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_SHIR}, 11'd0, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_SHDR}, 11'd0, 1'b0);
		add_req(REQ_FLUSH, 5'd0, 11'd0, 1'b1);
		add_req(REQ_FLUSH, 5'd0, 11'd0, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_TLR}, 11'd2047, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_RTI}, 11'd2047, 1'b0);
		for (int s = 0; s < 16; s++) begin
			if (!HOLD_MASK[s])
				add_req(REQ_GOTO, 5'(s), 11'd0, 1'b0);
		end
		add_req(REQ_GOTO, {1'b0, TAP_PDR}, 11'd64, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_PIR}, 11'd63, 1'b0);
		add_req(REQ_GOTO, {1'b0, TAP_UIR}, 11'd3, 1'b0);
		add_req(REQ_FLUSH, 5'd31, 11'd2047, 1'b0);

		for (int i = 0; i < 345; i++) begin
			roll  = $urandom_range(99);
			drain = (i == 120 || i == 260);
			if (roll < 12) begin
				add_req(REQ_FLUSH, 5'($urandom_range(31)), 11'($urandom_range(2047)), drain);
			end else if (roll < 17) begin
				add_req(REQ_GOTO, 5'($urandom_range(31, 16)), 11'($urandom_range(2047)), drain);
			end else begin
				tgt = 5'($urandom_range(15));
				if (!HOLD_MASK[tgt[3:0]]) begin
					wt = (roll < 23) ? 11'($urandom_range(2047, 1)) : 11'd0;
				end else begin
					sz = $urandom_range(99);
					if (sz < 70)
						wt = 11'($urandom_range(20));
					else if (sz < 95)
						wt = 11'($urandom_range(130));
					else
						wt = 11'($urandom_range(2047));
				end
				add_req(REQ_GOTO, tgt, wt, drain);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expect_total != got_total)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		mismatches = mismatches + tms_expect_q.size();
		$display("Run covered %0d requests (%0d flushes, %0d rejected), %0d result words checked.",
			accepted_n, flush_n, reject_n, got_total);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
